// File: rtl/core/bmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_pkg: shared definitions for the binomial-modulo-prime block
// Field widths, the prime and its Barrett constant, the inversion exponent,
// the word tag that rides along the pipeline, and the fill sequencer states.
// ----------------------------------------------------------------------------
package bmp_pkg;

    // Field widths.
    localparam int IN_W   = 12;
    localparam int COEF_W = 30;

    // Default depth of the factorial table.
    localparam int TABLE_DEPTH_DEF = 4096;

    // The prime modulus and its multiples used by the final correction.
    localparam logic [COEF_W-1:0] PRIME_MOD   = 30'd1000000007;
    localparam logic [31:0]       PRIME_MOD_X2 = 32'd2000000014;

    // Barrett reciprocal floor(2^60 / P), which fits in 31 bits.
    localparam logic [63:0] BARRETT_MU_FULL = (64'd1 << 60) / 64'd1000000007;
    localparam logic [30:0] BARRETT_MU      = BARRETT_MU_FULL[30:0];

    // Fermat inversion exponent P - 2, one cell per bit.
    localparam int                EXP_BITS  = 30;
    localparam logic [COEF_W-1:0] EXP_VALUE = 30'd1000000005;

    // Side information carried with each word through the arithmetic.
    typedef struct packed {
        logic              valid;
        logic              invalid;
        logic [COEF_W-1:0] numer;
    } t_tag;

    // Table fill sequencer states.
    typedef enum logic [1:0] {
        ST_INIT,
        ST_MUL,
        ST_WAIT,
        ST_RUN
    } t_fill_state;

endpackage

// File: rtl/core/bmp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_ram: factorial table storage
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bmp_ram #(
    parameter int DEPTH  = bmp_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [ADDR_W-1:0]         i_waddr,
    input  logic [bmp_pkg::COEF_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]         i_raddr,
    output logic [bmp_pkg::COEF_W-1:0] o_rdata
);

    logic [bmp_pkg::COEF_W-1:0] r_mem [0:DEPTH-1];
    logic [bmp_pkg::COEF_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bmp_modmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_modmul: pipelined modular multiplier
// Computes a * b mod P in five stages with Barrett reduction; a tag word
// travels alongside so that results stay paired with their side data.
// ----------------------------------------------------------------------------
module bmp_modmul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [bmp_pkg::COEF_W-1:0] i_a,
    input  logic [bmp_pkg::COEF_W-1:0] i_b,
    input  bmp_pkg::t_tag              i_tag,
    output logic [bmp_pkg::COEF_W-1:0] o_prod,
    output bmp_pkg::t_tag              o_tag
);

    logic [59:0] r_p1;
    logic [61:0] r_q2;
    logic [31:0] r_x2;
    logic [31:0] r_qp3;
    logic [31:0] r_x3;
    logic [31:0] r_r4;
    logic [bmp_pkg::COEF_W-1:0] r_out;
    bmp_pkg::t_tag r_tag [0:4];

    logic [60:0] n_qp_full;
    logic [31:0] n_red;

    // Quotient estimate times the prime; only the low word is needed.
    assign n_qp_full = r_q2[61:31] * bmp_pkg::PRIME_MOD;

    // Remainder is below 3P: subtract P once or twice.
    always_comb begin
        if (r_r4 >= bmp_pkg::PRIME_MOD_X2) begin
            n_red = r_r4 - bmp_pkg::PRIME_MOD_X2;
        end else if (r_r4 >= 32'(bmp_pkg::PRIME_MOD)) begin
            n_red = r_r4 - 32'(bmp_pkg::PRIME_MOD);
        end else begin
            n_red = r_r4;
        end
    end

    // Arithmetic stages: product, reciprocal, back-multiply, subtract, correct.
    always_ff @(posedge i_clk) begin
        r_p1  <= i_a * i_b;
        r_q2  <= r_p1[59:29] * bmp_pkg::BARRETT_MU;
        r_x2  <= r_p1[31:0];
        r_qp3 <= n_qp_full[31:0];
        r_x3  <= r_x2;
        r_r4  <= r_x3 - r_qp3;
        r_out <= n_red[bmp_pkg::COEF_W-1:0];
    end

    // Tag delay line; only the valid bits are cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) begin
                r_tag[k].valid <= 1'b0;
            end
        end else begin
            r_tag[0] <= i_tag;
            for (int k = 1; k < 5; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign o_prod = r_out;
    assign o_tag  = r_tag[4];

endmodule

// File: rtl/core/bmp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_cell: one square-and-multiply step of the Fermat inversion
// Squares the running power and, when its exponent bit is set, folds the
// power into the accumulator. Hands the word to the next cell every cycle.
// ----------------------------------------------------------------------------
module bmp_cell #(
    parameter logic EXP_BIT = 1'b1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [bmp_pkg::COEF_W-1:0] i_acc,
    input  logic [bmp_pkg::COEF_W-1:0] i_sq,
    input  bmp_pkg::t_tag              i_tag,
    output logic [bmp_pkg::COEF_W-1:0] o_acc,
    output logic [bmp_pkg::COEF_W-1:0] o_sq,
    output bmp_pkg::t_tag              o_tag
);

    logic [bmp_pkg::COEF_W-1:0] acc_factor;

    // A clear exponent bit multiplies the accumulator by one.
    assign acc_factor = EXP_BIT ? i_sq : bmp_pkg::COEF_W'(1);

    // Accumulator multiplier; the word tag rides with it.
    bmp_modmul u_acc_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (i_acc),
        .i_b     (acc_factor),
        .i_tag   (i_tag),
        .o_prod  (o_acc),
        .o_tag   (o_tag)
    );

    // Squaring multiplier.
    bmp_modmul u_sq_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (i_sq),
        .i_b     (i_sq),
        .i_tag   ('0),
        .o_prod  (o_sq),
        .o_tag   ()
    );

endmodule

// File: rtl/core/binomial_mod_prime.sv
`timescale 1ns / 1ps
// Pipeline: a query passes through the table read, the denominator multiply,
// 30 inversion cells of 5 stages each, the numerator multiply and the output
// register, which drives o_valid; the receiver cannot stall the pipeline.
// Throughput: one query per cycle while o_busy is low.
// Reset: after i_rst_n the block holds o_busy high while it builds the factorial
// table, one dependent multiply per entry.
// ----------------------------------------------------------------------------
// binomial_mod_prime: n choose r modulo 1000000007
// Looks up n!, r! and (n-r)! in three copies of a factorial table, inverts
// r!(n-r)! by Fermat exponentiation in a chain of cells and scales by n!.
// ----------------------------------------------------------------------------
module binomial_mod_prime #(
    parameter int TABLE_DEPTH = bmp_pkg::TABLE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [bmp_pkg::IN_W-1:0]   i_n_total,
    input  logic [bmp_pkg::IN_W-1:0]   i_r_choose,
    output logic                       o_valid,
    output logic [bmp_pkg::COEF_W-1:0] o_coef_value,
    output logic                       o_invalid
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int EXT_W  = ADDR_W + bmp_pkg::IN_W;

    // Fill sequencer.
    bmp_pkg::t_fill_state r_state, n_state;
    logic [ADDR_W-1:0]          r_idx;
    logic [bmp_pkg::COEF_W-1:0] r_prev;
    logic                       fill_issue;
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [bmp_pkg::COEF_W-1:0] ram_wdata;
    bmp_pkg::t_tag              fill_tag_in, fill_tag_out;
    logic [bmp_pkg::COEF_W-1:0] fill_prod;
    logic                       fill_last;

    // Query front end.
    logic                       accept;
    logic                       q_invalid;
    logic [bmp_pkg::IN_W-1:0]   q_diff;
    logic [EXT_W-1:0]           n_ext, r_ext, d_ext;
    logic [bmp_pkg::COEF_W-1:0] fact_n, fact_r, fact_d;
    logic                       r_rd_valid;
    logic                       r_rd_invalid;
    bmp_pkg::t_tag              rd_tag;

    // Inversion chain.
    logic [bmp_pkg::COEF_W-1:0] acc_chain [0:bmp_pkg::EXP_BITS];
    logic [bmp_pkg::COEF_W-1:0] sq_chain  [0:bmp_pkg::EXP_BITS];
    bmp_pkg::t_tag              tag_chain [0:bmp_pkg::EXP_BITS];

    // Back end.
    logic [bmp_pkg::COEF_W-1:0] fin_prod;
    bmp_pkg::t_tag              fin_tag;
    logic                       r_valid;
    logic [bmp_pkg::COEF_W-1:0] r_coef;
    logic                       r_invalid;

    // ------------------------------------------------------------------
    // Table fill: entry i = i * entry (i-1) mod P, one at a time.
    // ------------------------------------------------------------------
    assign fill_last = (r_idx == ADDR_W'(TABLE_DEPTH - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            bmp_pkg::ST_INIT: begin
                n_state = bmp_pkg::ST_MUL;
            end
            bmp_pkg::ST_MUL: begin
                n_state = bmp_pkg::ST_WAIT;
            end
            bmp_pkg::ST_WAIT: begin
                if (fill_tag_out.valid) begin
                    n_state = fill_last ? bmp_pkg::ST_RUN : bmp_pkg::ST_MUL;
                end
            end
            bmp_pkg::ST_RUN: begin
                n_state = bmp_pkg::ST_RUN;
            end
            default: begin
                n_state = bmp_pkg::ST_INIT;
            end
        endcase
    end

    always_comb begin
        fill_issue = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_idx;
        ram_wdata  = fill_prod;
        o_busy     = 1'b1;
        case (r_state)
            bmp_pkg::ST_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = bmp_pkg::COEF_W'(1);
            end
            bmp_pkg::ST_MUL: begin
                fill_issue = 1'b1;
            end
            bmp_pkg::ST_WAIT: begin
                ram_we = fill_tag_out.valid;
            end
            bmp_pkg::ST_RUN: begin
                o_busy = 1'b0;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmp_pkg::ST_INIT;
            r_idx   <= '0;
            r_prev  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == bmp_pkg::ST_INIT) begin
                r_idx  <= ADDR_W'(1);
                r_prev <= bmp_pkg::COEF_W'(1);
            end else if (r_state == bmp_pkg::ST_WAIT && fill_tag_out.valid) begin
                r_idx  <= r_idx + ADDR_W'(1);
                r_prev <= fill_prod;
            end
        end
    end

    assign fill_tag_in = '{valid: fill_issue, invalid: 1'b0, numer: '0};

    bmp_modmul u_fill_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (bmp_pkg::COEF_W'(r_idx)),
        .i_b     (r_prev),
        .i_tag   (fill_tag_in),
        .o_prod  (fill_prod),
        .o_tag   (fill_tag_out)
    );

    // ------------------------------------------------------------------
    // Query intake and table lookups.
    // ------------------------------------------------------------------
    assign accept    = i_start && !o_busy;
    assign q_diff    = i_n_total - i_r_choose;
    assign q_invalid = (i_r_choose > i_n_total)
                    || (32'(i_n_total) >= 32'(TABLE_DEPTH));
    assign n_ext     = EXT_W'(i_n_total);
    assign r_ext     = EXT_W'(i_r_choose);
    assign d_ext     = EXT_W'(q_diff);

    bmp_ram #(.DEPTH(TABLE_DEPTH), .ADDR_W(ADDR_W)) u_ram_n (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_ext[ADDR_W-1:0]),
        .o_rdata (fact_n)
    );

    bmp_ram #(.DEPTH(TABLE_DEPTH), .ADDR_W(ADDR_W)) u_ram_r (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ext[ADDR_W-1:0]),
        .o_rdata (fact_r)
    );

    bmp_ram #(.DEPTH(TABLE_DEPTH), .ADDR_W(ADDR_W)) u_ram_d (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (d_ext[ADDR_W-1:0]),
        .o_rdata (fact_d)
    );

    // Control bits registered alongside the table read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= accept;
        end
        r_rd_invalid <= q_invalid;
    end

    assign rd_tag = '{valid: r_rd_valid, invalid: r_rd_invalid, numer: fact_n};

    // Denominator r! * (n-r)! seeds the inversion chain.
    bmp_modmul u_den_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (fact_r),
        .i_b     (fact_d),
        .i_tag   (rd_tag),
        .o_prod  (sq_chain[0]),
        .o_tag   (tag_chain[0])
    );

    assign acc_chain[0] = bmp_pkg::COEF_W'(1);

    // ------------------------------------------------------------------
    // Inversion: one cell per exponent bit, least significant first.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < bmp_pkg::EXP_BITS; k++) begin : g_cell
        bmp_cell #(.EXP_BIT(bmp_pkg::EXP_VALUE[k])) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_acc   (acc_chain[k]),
            .i_sq    (sq_chain[k]),
            .i_tag   (tag_chain[k]),
            .o_acc   (acc_chain[k+1]),
            .o_sq    (sq_chain[k+1]),
            .o_tag   (tag_chain[k+1])
        );
    end

    // Scale the inverse by n!.
    bmp_modmul u_fin_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (acc_chain[bmp_pkg::EXP_BITS]),
        .i_b     (tag_chain[bmp_pkg::EXP_BITS].numer),
        .i_tag   (tag_chain[bmp_pkg::EXP_BITS]),
        .o_prod  (fin_prod),
        .o_tag   (fin_tag)
    );

    // Output register; invalid queries report zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= fin_tag.valid;
        end
        r_invalid <= fin_tag.invalid;
        r_coef    <= fin_tag.invalid ? '0 : fin_prod;
    end

    assign o_valid      = r_valid;
    assign o_coef_value = r_coef;
    assign o_invalid    = r_invalid;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_busy_stays_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |=> !o_busy)
        else $error("busy rose again after the table fill finished");

    a_no_word_during_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !o_valid)
        else $error("result word emitted while the table was still filling");

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid) |-> (o_coef_value == '0))
        else $error("invalid result word carries a nonzero value");

    a_value_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_coef_value < bmp_pkg::PRIME_MOD))
        else $error("result word is not reduced below the prime");

    a_fill_write_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bmp_pkg::ST_WAIT && fill_tag_out.valid) |=> (r_prev == $past(fill_prod)))
        else $error("fill sequencer lost a factorial product");

endmodule
